FILE: src/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants of the epoch reclamation tracker
// Holds the opcode and status codes, the reader slot record and defaults.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int READER_SLOTS_DEF = 64;
    localparam int RETIRE_DEPTH_DEF = 32;
    localparam int MAX_RESULTS      = 32;
    localparam int ID_W             = 22;
    localparam int CYC_W            = 32;
    localparam int HANDLE_W         = 32;
    localparam int GRACE_W          = 16;
    localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd8;

    localparam logic [2:0] OP_ATTACH  = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_RBEGIN  = 3'd2;
    localparam logic [2:0] OP_REND    = 3'd3;
    localparam logic [2:0] OP_WBEGIN  = 3'd4;
    localparam logic [2:0] OP_WEND    = 3'd5;
    localparam logic [2:0] OP_RETIRE  = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_ID    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // One reader slot: id 0 marks a free slot, cycle 0 an unlocked reader.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CYC_W-1:0] cyc;
    } slot_rec_t;

endpackage

FILE: src/erc_ram.sv
// ----------------------------------------------------------------------------
// erc_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module erc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/erc_cell.sv
// ----------------------------------------------------------------------------
// erc_cell: one reader slot of the rotating reader ring
// Holds one reader record and takes its neighbor's record on every shift.
// ----------------------------------------------------------------------------
module erc_cell
    import erc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  slot_rec_t slot_in,
    output slot_rec_t slot_out
);

    slot_rec_t slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (shift)
        begin
            slot_reg <= slot_in;
        end
    end

    assign slot_out = slot_reg;

endmodule

FILE: src/epoch_reclamation_tracker_unit.sv
// ----------------------------------------------------------------------------
// epoch_reclamation_tracker_unit: epoch-based reclamation engine
// Reader table as a rotating ring of cells, retire queue in a RAM.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as beats on the item channel (item_valid/item_ready)
// carrying opcode, reader_id and block_handle. Results leave as beats on the
// result channel (result_valid/result_ready); every command gives one beat,
// except writer end, which gives one beat per freed handle (at least one).
// The beat that closes a command has last set. The user writes the grace
// threshold via cfg_we/cfg_wdata only while idle; no logic enforces this.
// Sequence. Writer begin, retire, the undefined opcode and a zero reader id
// answer from the S_EMIT state through the output register. Remove, reader
// begin, reader end and writer end rotate the reader ring once before their
// first beat; attach rotates once, and a second time for a new reader when a
// slot is free. Writer end then reads the retire queue RAM for each freed
// handle through the S_PRD and S_PCHK states. One command is in work at a
// time; the next is taken once the current one has handed its last beat to
// the output register, so a waiting result does not hold off the next beat.
// Reset clears the ring, the cycles, the queue count and the output valid
// flag; the grace threshold returns to 8. A stalled receiver simply holds the
// output register; a writer end waits with its next freed handle meanwhile.
// ----------------------------------------------------------------------------
module epoch_reclamation_tracker_unit
    import erc_pkg::*;
#(
    parameter int READER_SLOTS = READER_SLOTS_DEF,
    parameter int RETIRE_DEPTH = RETIRE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [GRACE_W-1:0]  cfg_wdata,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [2:0]          opcode,
    input  logic [ID_W-1:0]     reader_id,
    input  logic [HANDLE_W-1:0] block_handle,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [1:0]          status,
    output logic [CYC_W-1:0]    cycle_value,
    output logic                freed_valid,
    output logic [HANDLE_W-1:0] freed_handle,
    output logic                last
);

    localparam int SW = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
    localparam int HW = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
    localparam int QW = $clog2(RETIRE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(READER_SLOTS - 1);
    localparam logic [HW-1:0] HEAD_LAST = HW'(RETIRE_DEPTH - 1);
    localparam logic [QW-1:0] QUEUE_FULL = QW'(RETIRE_DEPTH);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_RESULTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_PRD  = 3'd3;
    localparam logic [2:0] S_PCHK = 3'd4;

    // ---------------- reader ring ----------------
    // Cell 0 is the head that the controller inspects; on a shift the head
    // record, possibly updated, re-enters at the tail.
    slot_rec_t ring [READER_SLOTS];
    slot_rec_t tail_in;
    logic      shift;

    for (genvar g = 0; g < READER_SLOTS; g++)
    begin : g_ring
        slot_rec_t nb;
        if (g == READER_SLOTS - 1)
        begin : g_tail
            assign nb = tail_in;
        end
        else
        begin : g_mid
            assign nb = ring[g+1];
        end
        erc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .slot_in  (nb),
            .slot_out (ring[g])
        );
    end

    // ---------------- control registers ----------------
    logic [2:0]          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic                hit_reg, hit_next;
    logic                free_reg, free_next;
    logic                pass2_reg, pass2_next;
    logic                found_reg, found_next;
    logic [CYC_W-1:0]    oldest_reg, oldest_next;
    logic [CYC_W-1:0]    target_reg, target_next;
    logic [CYC_W-1:0]    lim_reg, lim_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                pend_reg, pend_next;
    logic [HANDLE_W-1:0] pend_h_reg, pend_h_next;
    logic [GRACE_W-1:0]  grace_reg;
    logic [CYC_W-1:0]    wcyc_reg, wcyc_next;
    logic [CYC_W-1:0]    hor_reg, hor_next;
    logic [HW-1:0]       head_reg, head_next;
    logic [QW-1:0]       qcnt_reg, qcnt_next;

    // staged single result
    logic [1:0]          rs_st_reg, rs_st_next;
    logic [CYC_W-1:0]    rs_cyc_reg, rs_cyc_next;

    // output register
    logic                ov_reg, ov_next;
    logic [1:0]          o_st_reg, o_st_next;
    logic [CYC_W-1:0]    o_cyc_reg, o_cyc_next;
    logic                o_fv_reg, o_fv_next;
    logic [HANDLE_W-1:0] o_fh_reg, o_fh_next;
    logic                o_last_reg, o_last_next;

    // ---------------- retire queue RAM ----------------
    logic                          q_we;
    logic [HW-1:0]                 q_waddr;
    logic [CYC_W+HANDLE_W-1:0]     q_rdata;
    logic [QW:0]                   tail_sum;

    assign tail_sum = {1'b0, qcnt_reg} + (QW+1)'(head_reg);
    assign q_waddr  = (tail_sum >= (QW+1)'(RETIRE_DEPTH))
                    ? HW'(tail_sum - (QW+1)'(RETIRE_DEPTH)) : HW'(tail_sum);

    erc_ram #(
        .WIDTH (CYC_W + HANDLE_W),
        .DEPTH (RETIRE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata ({wcyc_reg, block_handle}),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // ---------------- combinational control ----------------
    logic               slot_free;
    logic               head_match;
    logic               head_empty;
    logic [CYC_W-1:0]   age;
    logic               age_take;
    logic [CYC_W-1:0]   tgt;
    logic [CYC_W-1:0]   hdiff;
    logic [CYC_W-1:0]   lim_raw;
    logic [CYC_W-1:0]   q_cyc;
    logic [CYC_W-1:0]   ediff;
    logic               eligible;

    assign slot_free  = !ov_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign head_match = (ring[0].id == id_reg);
    assign head_empty = (ring[0].id == '0);
    assign age        = wcyc_reg - ring[0].cyc;
    assign age_take   = !head_empty && (ring[0].cyc != '0)
                     && (!found_reg || ($signed(age) >= $signed(oldest_reg)));
    assign tgt        = (found_reg || age_take)
                      ? (age_take ? ring[0].cyc : target_reg) : wcyc_reg;
    assign hdiff      = tgt - hor_reg;
    assign lim_raw    = tgt - CYC_W'(grace_reg);
    assign q_cyc      = q_rdata[CYC_W+HANDLE_W-1:HANDLE_W];
    assign ediff      = lim_reg - q_cyc;
    assign eligible   = (lim_reg == '0) || (q_cyc == '0)
                     || (!ediff[CYC_W-1] && (ediff != '0));

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        cnt_next    = cnt_reg;
        hit_next    = hit_reg;
        free_next   = free_reg;
        pass2_next  = pass2_reg;
        found_next  = found_reg;
        oldest_next = oldest_reg;
        target_next = target_reg;
        lim_next    = lim_reg;
        n_next      = n_reg;
        pend_next   = pend_reg;
        pend_h_next = pend_h_reg;
        wcyc_next   = wcyc_reg;
        hor_next    = hor_reg;
        head_next   = head_reg;
        qcnt_next   = qcnt_reg;
        rs_st_next  = rs_st_reg;
        rs_cyc_next = rs_cyc_reg;
        ov_next     = ov_reg && !result_ready;
        o_st_next   = o_st_reg;
        o_cyc_next  = o_cyc_reg;
        o_fv_next   = o_fv_reg;
        o_fh_next   = o_fh_reg;
        o_last_next = o_last_reg;
        shift       = 1'b0;
        tail_in     = ring[0];
        q_we        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next     = opcode;
                    id_next     = reader_id;
                    cnt_next    = '0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    pass2_next  = 1'b0;
                    found_next  = 1'b0;
                    rs_st_next  = ST_OK;
                    rs_cyc_next = '0;
                    state_next  = S_EMIT;
                    if ((opcode <= OP_REND) && (reader_id == '0))
                    begin
                        rs_st_next = ST_BAD_ID;
                    end
                    else if ((opcode <= OP_REND) || (opcode == OP_WEND))
                    begin
                        state_next = S_SCAN;
                    end
                    else if (opcode == OP_WBEGIN)
                    begin
                        wcyc_next   = (wcyc_reg == '1) ? CYC_W'(1) : wcyc_reg + 1'b1;
                        rs_cyc_next = (wcyc_reg == '1) ? CYC_W'(1) : wcyc_reg + 1'b1;
                    end
                    else if (opcode == OP_RETIRE)
                    begin
                        if (qcnt_reg == QUEUE_FULL)
                        begin
                            rs_st_next = ST_FULL;
                        end
                        else
                        begin
                            q_we      = 1'b1;
                            qcnt_next = qcnt_reg + 1'b1;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == OP_WEND)
                begin
                    if (age_take)
                    begin
                        found_next  = 1'b1;
                        oldest_next = age;
                        target_next = ring[0].cyc;
                    end
                end
                else if (op_reg == OP_ATTACH)
                begin
                    if (pass2_reg)
                    begin
                        if (head_empty && !hit_reg)
                        begin
                            tail_in  = '{id: id_reg, cyc: '0};
                            hit_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (head_match)
                        begin
                            hit_next = 1'b1;
                        end
                        if (head_empty)
                        begin
                            free_next = 1'b1;
                        end
                    end
                end
                else if (head_match && !hit_reg)
                begin
                    hit_next = 1'b1;
                    priority case (op_reg)
                        OP_REMOVE: tail_in = '0;
                        OP_RBEGIN: tail_in = '{id: id_reg, cyc: wcyc_reg};
                        default:   tail_in = '{id: id_reg, cyc: '0};
                    endcase
                end

                if (cnt_reg == SLOT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                    rs_st_next = ST_OK;
                    if (op_reg == OP_WEND)
                    begin
                        n_next    = '0;
                        pend_next = 1'b0;
                        if (!hdiff[CYC_W-1] && (hdiff > CYC_W'(grace_reg)))
                        begin
                            hor_next   = tgt;
                            lim_next   = (tgt == '0) ? '0
                                       : ((lim_raw == '0) ? '1 : lim_raw);
                            state_next = S_PRD;
                        end
                    end
                    else if (op_reg == OP_ATTACH)
                    begin
                        if (!pass2_reg && !(hit_reg || head_match))
                        begin
                            if (free_reg || head_empty)
                            begin
                                pass2_next = 1'b1;
                                hit_next   = 1'b0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                rs_st_next = ST_NOT_FOUND;
                            end
                        end
                    end
                    else if (hit_reg || head_match)
                    begin
                        rs_cyc_next = (op_reg == OP_RBEGIN) ? wcyc_reg : '0;
                    end
                    else
                    begin
                        rs_st_next = ST_NOT_FOUND;
                    end
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    o_st_next   = rs_st_reg;
                    o_cyc_next  = rs_cyc_reg;
                    o_fv_next   = 1'b0;
                    o_fh_next   = '0;
                    o_last_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_PRD:
            begin
                if ((qcnt_reg != '0) && (n_reg != N_MAX))
                begin
                    state_next = S_PCHK;
                end
                else if (slot_free)
                begin
                    // Close the command: the held handle, or an empty beat.
                    ov_next     = 1'b1;
                    o_st_next   = ST_OK;
                    o_cyc_next  = '0;
                    o_fv_next   = pend_reg;
                    o_fh_next   = pend_reg ? pend_h_reg : '0;
                    o_last_next = 1'b1;
                    pend_next   = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            S_PCHK:
            begin
                if (!eligible)
                begin
                    n_next     = N_MAX;
                    state_next = S_PRD;
                end
                else if (!pend_reg || slot_free)
                begin
                    if (pend_reg)
                    begin
                        ov_next     = 1'b1;
                        o_st_next   = ST_OK;
                        o_cyc_next  = '0;
                        o_fv_next   = 1'b1;
                        o_fh_next   = pend_h_reg;
                        o_last_next = 1'b0;
                    end
                    pend_next   = 1'b1;
                    pend_h_next = q_rdata[HANDLE_W-1:0];
                    head_next   = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                    qcnt_next   = qcnt_reg - 1'b1;
                    n_next      = n_reg + 1'b1;
                    state_next  = S_PRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grace_reg <= GRACE_RESET;
            wcyc_reg  <= '0;
            hor_reg   <= '0;
            head_reg  <= '0;
            qcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                grace_reg <= cfg_wdata;
            end
            wcyc_reg  <= wcyc_next;
            hor_reg   <= hor_next;
            head_reg  <= head_next;
            qcnt_reg  <= qcnt_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        cnt_reg    <= cnt_next;
        hit_reg    <= hit_next;
        free_reg   <= free_next;
        pass2_reg  <= pass2_next;
        found_reg  <= found_next;
        oldest_reg <= oldest_next;
        target_reg <= target_next;
        lim_reg    <= lim_next;
        n_reg      <= n_next;
        pend_h_reg <= pend_h_next;
        rs_st_reg  <= rs_st_next;
        rs_cyc_reg <= rs_cyc_next;
        o_st_reg   <= o_st_next;
        o_cyc_reg  <= o_cyc_next;
        o_fv_reg   <= o_fv_next;
        o_fh_reg   <= o_fh_next;
        o_last_reg <= o_last_next;
    end

    assign result_valid = ov_reg;
    assign status       = o_st_reg;
    assign cycle_value  = o_cyc_reg;
    assign freed_valid  = o_fv_reg;
    assign freed_handle = o_fh_reg;
    assign last         = o_last_reg;

    // ---------------- assertions ----------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QUEUE_FULL)
        else $error("retire queue count exceeds its depth");

    a_write_cycle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && item_valid && (opcode == OP_WBEGIN) |=> wcyc_reg != '0)
        else $error("write cycle took the value zero");

    a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && freed_valid |-> (status == ST_OK) && (cycle_value == '0))
        else $error("freed handle beat with error status or cycle");

    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_PRD) || (state_reg == S_PCHK))
        else $error("held freed handle outside collection");

endmodule
